// ===== design/gdnw_pkg.sv =====
// shared types, constants and tables for the gregorian day number core
// no dependencies; imported by every module of the core
package gdnw_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DNUM_W  = 22;
    localparam int DOY_W   = 9;
    localparam int WD_W    = 3;
    localparam int WEEK_W  = 6;
    localparam int Q100_W  = 8;
    localparam int Q7_W    = 19;
    localparam int WSUM_W  = 9;

    localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1601;
    localparam logic [YEAR_W-1:0]  LAST_YEAR  = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;

    // floor(x / 100) = (x * RECIP100) >> SH100 for x < 2**14
    localparam logic [12:0] RECIP100 = 13'd5243;
    localparam int          SH100    = 19;
    // floor(x / 7) = (x * RECIP7) >> SH7 for x < 2**22
    localparam logic [22:0] RECIP7   = 23'd4793491;
    localparam int          SH7      = 25;
    // floor(x / 7) = (x * RECIP7S) >> SH7S for x < 2**9
    localparam logic [10:0] RECIP7S  = 11'd1171;
    localparam int          SH7S     = 13;

    localparam logic [8:0] DAYS_YEAR = 9'd365;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day_of_month;
    } ymd_t;

    typedef struct packed {
        logic               year_ok;
        logic               month_ok;
        logic               leap;
        logic [DNUM_W-1:0]  base;
        logic [DOY_W-1:0]   mstart;
        logic [DAY_W-1:0]   mlen;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day_of_month;
    } yr_t;

    typedef struct packed {
        logic              ok;
        logic              leap;
        logic [DOY_W-1:0]  doy;
        logic [DNUM_W-1:0] num;
        logic [DNUM_W-1:0] num1;
        logic [DNUM_W-1:0] base1;
        logic [Q7_W-1:0]   q_num;
        logic [Q7_W-1:0]   q_base;
    } dn_t;

    typedef struct packed {
        logic              valid_res;
        logic [WEEK_W-1:0] week_number;
        logic              is_leap;
        logic [DOY_W-1:0]  day_of_year;
        logic [WD_W-1:0]   weekday;
        logic [DNUM_W-1:0] day_number;
    } res_t;

    function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] r;
        unique case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] r;
        unique case (m)
            4'd2:                                  r = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:               r = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10,
            4'd12:                                 r = 5'd31;
            default:                               r = 5'd0;
        endcase
        return r;
    endfunction

    // week offset by weekday of january 1, held as delta + 3
    function automatic logic [2:0] jan1_bias(input logic [WD_W-1:0] wd);
        logic [2:0] r;
        unique case (wd)
            3'd0:    r = 3'd2;
            3'd1:    r = 3'd3;
            3'd2:    r = 3'd4;
            3'd3:    r = 3'd5;
            3'd4:    r = 3'd6;
            3'd5:    r = 3'd0;
            3'd6:    r = 3'd1;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/gdnw_year.sv =====
// year stages: range checks, month tables, divisions by 100, leap flag, start of year
// depends on gdnw_pkg
module gdnw_year (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  gdnw_pkg::ymd_t in_word,
    output logic          out_valid,
    input  logic          out_ready,
    output gdnw_pkg::yr_t  out_word
);
    import gdnw_pkg::*;

    logic [2:0] vld_reg;
    logic [2:0] vld_next;
    logic [3:0] rdy;

    // stage 0
    logic [YEAR_W-1:0]  s0_y_reg, s0_yy_reg;
    logic [MONTH_W-1:0] s0_m_reg;
    logic [DAY_W-1:0]   s0_d_reg;
    logic               s0_yok_reg, s0_mok_reg;
    logic [DOY_W-1:0]   s0_mstart_reg;
    logic [DAY_W-1:0]   s0_mlen_reg;
    // stage 1
    logic [YEAR_W-1:0]  s1_y_reg, s1_yy_reg;
    logic [Q100_W-1:0]  s1_qy_reg, s1_qyy_reg;
    logic [MONTH_W-1:0] s1_m_reg;
    logic [DAY_W-1:0]   s1_d_reg;
    logic               s1_yok_reg, s1_mok_reg;
    logic [DOY_W-1:0]   s1_mstart_reg;
    logic [DAY_W-1:0]   s1_mlen_reg;
    // stage 2
    yr_t                s2_reg;

    logic [26:0]        prod_y, prod_yy;
    logic [YEAR_W-1:0]  hundreds_y;
    logic               cent_year;
    logic               leap_next;
    logic [22:0]        base_wide;

    always_comb begin
        rdy[3] = out_ready;
        for (int i = 2; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        vld_next = vld_reg;
        if (rdy[0]) vld_next[0] = in_valid;
        if (rdy[1]) vld_next[1] = vld_reg[0];
        if (rdy[2]) vld_next[2] = vld_reg[1];
    end

    assign in_ready  = rdy[0] && aresetn;
    assign out_valid = vld_reg[2];
    assign out_word  = s2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            s0_y_reg      <= in_word.year;
            s0_yy_reg     <= in_word.year - YEAR_MIN;
            s0_m_reg      <= in_word.month;
            s0_d_reg      <= in_word.day_of_month;
            s0_yok_reg    <= (in_word.year >= YEAR_MIN) && (in_word.year <= LAST_YEAR);
            s0_mok_reg    <= (in_word.month >= MONTH_JAN) && (in_word.month <= MONTH_DEC);
            s0_mstart_reg <= month_start(in_word.month);
            s0_mlen_reg   <= month_len(in_word.month);
        end
    end

    assign prod_y  = 27'(s0_y_reg) * 27'(RECIP100);
    assign prod_yy = 27'(s0_yy_reg) * 27'(RECIP100);

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            s1_y_reg      <= s0_y_reg;
            s1_yy_reg     <= s0_yy_reg;
            s1_qy_reg     <= prod_y[SH100 +: Q100_W];
            s1_qyy_reg    <= prod_yy[SH100 +: Q100_W];
            s1_m_reg      <= s0_m_reg;
            s1_d_reg      <= s0_d_reg;
            s1_yok_reg    <= s0_yok_reg;
            s1_mok_reg    <= s0_mok_reg;
            s1_mstart_reg <= s0_mstart_reg;
            s1_mlen_reg   <= s0_mlen_reg;
        end
    end

    always_comb begin
        hundreds_y = YEAR_W'(14'(s1_qy_reg) * 14'd100);
        cent_year  = (hundreds_y == s1_y_reg);
        leap_next  = (s1_y_reg[1:0] == 2'b00) && (!cent_year || (s1_qy_reg[1:0] == 2'b00));
        base_wide  = 23'(s1_yy_reg) * 23'(DAYS_YEAR)
                   + 23'(s1_yy_reg >> 2)
                   - 23'(s1_qyy_reg)
                   + 23'(s1_qyy_reg >> 2);
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            s2_reg.year_ok      <= s1_yok_reg;
            s2_reg.month_ok     <= s1_mok_reg;
            s2_reg.leap         <= leap_next;
            s2_reg.base         <= base_wide[DNUM_W-1:0];
            s2_reg.mstart       <= s1_mstart_reg;
            s2_reg.mlen         <= s1_mlen_reg;
            s2_reg.month        <= s1_m_reg;
            s2_reg.day_of_month <= s1_d_reg;
        end
    end

endmodule

// ===== design/gdnw_day.sv =====
// day stages: date check, day of year, day number, quotients by seven
// depends on gdnw_pkg
module gdnw_day (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  gdnw_pkg::yr_t  in_word,
    output logic          out_valid,
    input  logic          out_ready,
    output gdnw_pkg::dn_t  out_word
);
    import gdnw_pkg::*;

    logic [1:0] vld_reg;
    logic [1:0] vld_next;
    logic [2:0] rdy;

    dn_t s0_reg;
    dn_t s1_reg;
    dn_t s1_next;

    logic [DAY_W-1:0]  len;
    logic              ok_next;
    logic [DOY_W-1:0]  doy_next;
    logic [DNUM_W-1:0] num_next;
    logic [44:0]       prod_num, prod_base;

    always_comb begin
        rdy[2] = out_ready;
        rdy[1] = !vld_reg[1] || rdy[2];
        rdy[0] = !vld_reg[0] || rdy[1];
        vld_next = vld_reg;
        if (rdy[0]) vld_next[0] = in_valid;
        if (rdy[1]) vld_next[1] = vld_reg[0];
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[1];
    assign out_word  = s1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_comb begin
        len      = in_word.mlen + DAY_W'((in_word.month == MONTH_FEB) && in_word.leap);
        ok_next  = in_word.year_ok && in_word.month_ok && (in_word.day_of_month != '0)
                   && (in_word.day_of_month <= len);
        doy_next = in_word.mstart + DOY_W'(in_word.day_of_month)
                 + DOY_W'((in_word.month > MONTH_FEB) && in_word.leap);
        num_next = in_word.base + DNUM_W'(doy_next) - 22'd1;
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            s0_reg.ok     <= ok_next;
            s0_reg.leap   <= in_word.leap;
            s0_reg.doy    <= doy_next;
            s0_reg.num    <= num_next;
            s0_reg.num1   <= in_word.base + DNUM_W'(doy_next);
            s0_reg.base1  <= in_word.base + 22'd1;
            s0_reg.q_num  <= '0;
            s0_reg.q_base <= '0;
        end
    end

    assign prod_num  = 45'(s0_reg.num1) * 45'(RECIP7);
    assign prod_base = 45'(s0_reg.base1) * 45'(RECIP7);

    always_comb begin
        s1_next        = s0_reg;
        s1_next.q_num  = prod_num[SH7 +: Q7_W];
        s1_next.q_base = prod_base[SH7 +: Q7_W];
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            s1_reg <= s1_next;
        end
    end

endmodule

// ===== design/gdnw_week.sv =====
// week stages: weekday remainders, week sum and division by seven, result word
// depends on gdnw_pkg
module gdnw_week (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  gdnw_pkg::dn_t   in_word,
    output logic           out_valid,
    input  logic           out_ready,
    output gdnw_pkg::res_t  out_word
);
    import gdnw_pkg::*;

    logic [1:0] vld_reg;
    logic [1:0] vld_next;
    logic [2:0] rdy;

    logic              s0_ok_reg, s0_leap_reg;
    logic [DOY_W-1:0]  s0_doy_reg;
    logic [DNUM_W-1:0] s0_num_reg;
    logic [WD_W-1:0]   s0_wd_reg;
    logic [WSUM_W-1:0] s0_wsum_reg;
    res_t              s1_reg;

    logic [DNUM_W-1:0] rem_num, rem_base;
    logic [WD_W-1:0]   jan1;
    logic [19:0]       prod_week;

    always_comb begin
        rdy[2] = out_ready;
        rdy[1] = !vld_reg[1] || rdy[2];
        rdy[0] = !vld_reg[0] || rdy[1];
        vld_next = vld_reg;
        if (rdy[0]) vld_next[0] = in_valid;
        if (rdy[1]) vld_next[1] = vld_reg[0];
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[1];
    assign out_word  = s1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_comb begin
        rem_num  = in_word.num1 - DNUM_W'(22'(in_word.q_num) * 22'd7);
        rem_base = in_word.base1 - DNUM_W'(22'(in_word.q_base) * 22'd7);
        jan1     = rem_base[WD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            s0_ok_reg   <= in_word.ok;
            s0_leap_reg <= in_word.leap;
            s0_doy_reg  <= in_word.doy;
            s0_num_reg  <= in_word.num;
            s0_wd_reg   <= rem_num[WD_W-1:0];
            s0_wsum_reg <= WSUM_W'(in_word.doy) + WSUM_W'(jan1_bias(jan1)) + 9'd3;
        end
    end

    assign prod_week = 20'(s0_wsum_reg) * 20'(RECIP7S);

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            s1_reg.valid_res   <= s0_ok_reg;
            s1_reg.day_number  <= s0_ok_reg ? s0_num_reg : '0;
            s1_reg.weekday     <= s0_ok_reg ? s0_wd_reg : '0;
            s1_reg.day_of_year <= s0_ok_reg ? s0_doy_reg : '0;
            s1_reg.is_leap     <= s0_ok_reg && s0_leap_reg;
            s1_reg.week_number <= s0_ok_reg ? prod_week[SH7S +: WEEK_W] : '0;
        end
    end

endmodule

// ===== design/gregorian_day_number_weekday_week_core.sv =====
// top level of the gregorian day number, weekday and week core
// depends on gdnw_pkg, gdnw_year, gdnw_day and gdnw_week
//
// usage
// - input stream s_axis_*: one date word per handshake (year, month, day of month)
// - output stream m_axis_*: one result word per date; tuser is 1 for a valid date,
//   and an invalid date gives a word of all zeros
// - one word per cycle sustained while the receiver keeps tready high; the seven
//   register stages hold year range and month tables, the divisions by 100, leap
//   flag and start of year, date check and day number, the divisions by seven,
//   weekday remainders, then the week division and result
// - every stage has its own valid bit and stall control, so a stalled receiver
//   holds the output word steady while earlier stages keep filling empty slots;
//   input is refused only once all seven stages hold words, or while aresetn is low
// - reset clears every valid bit; the core takes a word in the cycle after reset
module gregorian_day_number_weekday_week_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // year[13:0], month[17:14], day_of_month[22:18]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // day_number[21:0], weekday[24:22],
                                        // day_of_year[33:25], is_leap[34], week_number[40:35]
    output logic        m_axis_tuser    // valid_res
);
    import gdnw_pkg::*;

    ymd_t in_word;
    yr_t  yr_word;
    dn_t  dn_word;
    res_t res_word;

    logic yr_valid, yr_ready;
    logic dn_valid, dn_ready;

    assign in_word.year         = s_axis_tdata[13:0];
    assign in_word.month        = s_axis_tdata[17:14];
    assign in_word.day_of_month = s_axis_tdata[22:18];

    gdnw_year u_year (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_word   (in_word),
        .out_valid (yr_valid),
        .out_ready (yr_ready),
        .out_word  (yr_word)
    );

    gdnw_day u_day (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (yr_valid),
        .in_ready  (yr_ready),
        .in_word   (yr_word),
        .out_valid (dn_valid),
        .out_ready (dn_ready),
        .out_word  (dn_word)
    );

    gdnw_week u_week (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dn_valid),
        .in_ready  (dn_ready),
        .in_word   (dn_word),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (res_word)
    );

    assign m_axis_tdata = {7'd0, res_word.week_number, res_word.is_leap,
                           res_word.day_of_year, res_word.weekday, res_word.day_number};
    assign m_axis_tuser = res_word.valid_res;

    // a full pipeline only arises behind a stalled output word
    a_full_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input refused without output stall");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("invalid date gave non-zero word");

    a_valid_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser) |->
        ((m_axis_tdata[24:22] != 3'd7) && (m_axis_tdata[33:25] != 9'd0)
         && (m_axis_tdata[40:35] <= 6'd53)))
        else $error("valid result out of range");

    a_day366_leap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser && (m_axis_tdata[33:25] == 9'd366))
        |-> m_axis_tdata[34])
        else $error("day 366 in a common year");

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the gregorian day number, weekday and week core
// predicts each result word from the date word it was sent and compares field by field
// depends on gdnw_pkg and gregorian_day_number_weekday_week_core
`timescale 1ns / 100ps

module testbench;

    import gdnw_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SINK_HOLD      = 80;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic [WD_W-1:0] {SUN, MON, TUE, WED, THU, FRI, SAT} weekday_t;

    typedef struct packed {
        logic              valid_res;
        logic [DNUM_W-1:0] day_number;
        logic [WD_W-1:0]   weekday;
        logic [DOY_W-1:0]  day_of_year;
        logic              is_leap;
        logic [WEEK_W-1:0] week_number;
    } date_result_t;

    localparam int unsigned DAYS_BEFORE [1:12] =
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    localparam int unsigned MONTH_DAYS [1:12] =
        '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // year[13:0], month[17:14], day_of_month[22:18]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // day_number[21:0], weekday[24:22],
                                 // day_of_year[33:25], is_leap[34], week_number[40:35]
    logic        m_axis_tuser;   // valid_res

    date_result_t pending_results[$];
    int           mismatch_count = 0;
    int           idle_cycles    = 0;
    bit           steady         = 1'b0;
    bit           sink_hold_req  = 1'b0;
    bit           sink_holding   = 1'b0;

    gregorian_day_number_weekday_week_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic bit leap_year(input logic [YEAR_W-1:0] y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned length_of_month(input logic [YEAR_W-1:0] y,
                                                    input logic [MONTH_W-1:0] m);
        if (m == MONTH_FEB && leap_year(y))
            return 29;
        return MONTH_DAYS[m];
    endfunction

    function automatic date_result_t predict_date(input logic [YEAR_W-1:0]  y,
                                                  input logic [MONTH_W-1:0] m,
                                                  input logic [DAY_W-1:0]   d);
        date_result_t r;
        int unsigned  yy, year_base, doy, num, week_bias;
        weekday_t     jan1;
        bit           leap;
        r = '0;
        if (y < YEAR_MIN || y > LAST_YEAR || m < MONTH_JAN || m > MONTH_DEC)
            return r;
        if (d == 0 || d > length_of_month(y, m))
            return r;
        leap      = leap_year(y);
        doy       = DAYS_BEFORE[m] + d + ((leap && m > MONTH_FEB) ? 1 : 0);
        yy        = y - YEAR_MIN;
        year_base = 365 * yy + yy / 4 - yy / 100 + yy / 400;
        num       = year_base + doy - 1;
        jan1      = weekday_t'((year_base + 1) % 7);
        // week shift plus six, by weekday of january 1
        case (jan1)
            MON:     week_bias = 6;
            TUE:     week_bias = 7;
            WED:     week_bias = 8;
            THU:     week_bias = 9;
            FRI:     week_bias = 3;
            SAT:     week_bias = 4;
            default: week_bias = 5;
        endcase
        r.valid_res   = 1'b1;
        r.day_number  = DNUM_W'(num);
        r.weekday     = WD_W'((num + 1) % 7);
        r.day_of_year = DOY_W'(doy);
        r.is_leap     = leap;
        r.week_number = WEEK_W'((doy + week_bias) / 7);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic note_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    task automatic send_date(input logic [YEAR_W-1:0]  y,
                             input logic [MONTH_W-1:0] m,
                             input logic [DAY_W-1:0]   d);
        int gap;
        s_axis_tdata  <= {1'b0, d, m, y};
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        pending_results.push_back(predict_date(y, m, d));
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // well-formed date, weighted towards the turn of the year
    task automatic send_valid_date();
        logic [YEAR_W-1:0]  y;
        logic [MONTH_W-1:0] m;
        logic [DAY_W-1:0]   d;
        y = YEAR_W'($urandom_range(YEAR_MIN, LAST_YEAR));
        if ($urandom_range(0, 4) == 0) begin
            if ($urandom_range(0, 1) == 0) begin
                m = MONTH_JAN;
                d = DAY_W'($urandom_range(1, 7));
            end else begin
                m = MONTH_DEC;
                d = DAY_W'($urandom_range(25, 31));
            end
        end else begin
            m = MONTH_W'($urandom_range(MONTH_JAN, MONTH_DEC));
            d = DAY_W'($urandom_range(1, length_of_month(y, m)));
        end
        send_date(y, m, d);
    endtask

    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge aclk);
    endtask

    task automatic test_directed();
        send_date(14'd1601, 4'd1, 5'd1);
        send_date(14'd9999, 4'd12, 5'd31);
        send_date(14'd1600, 4'd12, 5'd31);
        send_date(14'd10000, 4'd1, 5'd1);
        send_date(14'h3FFF, 4'hF, 5'h1F);
        send_date(14'd0, 4'd0, 5'd0);
        send_date(14'd2000, 4'd0, 5'd10);
        send_date(14'd2000, 4'd13, 5'd10);
        send_date(14'd2001, 4'd3, 5'd0);
        send_date(14'd2001, 4'd1, 5'd31);
        send_date(14'd2001, 4'd4, 5'd31);
        send_date(14'd2000, 4'd2, 5'd29);
        send_date(14'd1700, 4'd2, 5'd29);
        send_date(14'd1604, 4'd2, 5'd29);
        send_date(14'd2001, 4'd2, 5'd29);
        send_date(14'd1700, 4'd2, 5'd28);
        send_date(14'd2000, 4'd12, 5'd31);
        // january 1 on friday, saturday, sunday: week zero; on thursday: week one
        send_date(14'd2010, 4'd1, 5'd1);
        send_date(14'd2011, 4'd1, 5'd1);
        send_date(14'd2012, 4'd1, 5'd1);
        send_date(14'd2015, 4'd1, 5'd1);
        // late december in next year's first week keeps week 53
        send_date(14'd2020, 4'd12, 5'd31);
        send_date(14'd2018, 4'd12, 5'd31);
        send_date(14'd2004, 4'd3, 5'd1);
        send_date(14'd8192, 4'd8, 5'd16);
    endtask

    task automatic test_random();
        int i;
        for (i = 0; i < 420; i++) begin
            steady = (i % 100) < 25;
            if ($urandom_range(0, 4) == 0)
                send_date(YEAR_W'($urandom_range(0, 16383)), MONTH_W'($urandom_range(0, 15)),
                          DAY_W'($urandom_range(0, 31)));
            else
                send_valid_date();
        end
        steady = 1'b0;
    endtask

    task automatic test_backpressure();
        int i;
        steady        = 1'b1;
        sink_hold_req = 1'b1;
        wait (sink_holding);
        for (i = 0; i < 40; i++)
            send_valid_date();
        steady = 1'b0;
    endtask

    task automatic test_drain_pause();
        int i;
        for (i = 0; i < 10; i++)
            send_valid_date();
        wait_until_drained();
        for (i = 0; i < 10; i++)
            send_valid_date();
    endtask

    initial begin
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        test_backpressure();
        test_drain_pause();
        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // receiver: random stalls, or one long hold when asked
    initial begin : sink
        int n;
        m_axis_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (sink_hold_req) begin
                m_axis_tready <= 1'b0;
                sink_holding = 1'b1;
                repeat (SINK_HOLD) @(posedge aclk);
                sink_holding  = 1'b0;
                sink_hold_req = 1'b0;
            end else if (steady || $urandom_range(0, 3) != 0) begin
                m_axis_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                n = pick_gap();
                if (n == 0)
                    n = 1;
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        date_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected word", 0, m_axis_tdata[DNUM_W-1:0]);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.valid_res)
                    note_mismatch("valid_res", want.valid_res, m_axis_tuser);
                if (m_axis_tdata[21:0] !== want.day_number)
                    note_mismatch("day_number", want.day_number, m_axis_tdata[21:0]);
                if (m_axis_tdata[24:22] !== want.weekday)
                    note_mismatch("weekday", want.weekday, m_axis_tdata[24:22]);
                if (m_axis_tdata[33:25] !== want.day_of_year)
                    note_mismatch("day_of_year", want.day_of_year, m_axis_tdata[33:25]);
                if (m_axis_tdata[34] !== want.is_leap)
                    note_mismatch("is_leap", want.is_leap, m_axis_tdata[34]);
                if (m_axis_tdata[40:35] !== want.week_number)
                    note_mismatch("week_number", want.week_number, m_axis_tdata[40:35]);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule
